[design/assert_macros.svh]
// Assertion macros shared by the RTL of the radix digit converter.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SIRD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SIRD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/sird_pkg.sv]
// Package for the signed integer to radix digits converter: widths, register
// indexes, reset values, state encoding and the symbol lookup function.
// No dependencies.
`timescale 1ns / 1ps

package sird_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int MAX_SYMBOLS     = 16;
    localparam int BASE_W          = 5;
    localparam int DIGIT_W         = 4;
    localparam int CHAR_W          = 8;
    localparam int SYM_W           = 64;
    localparam int CFG_IDX_W       = 2;

    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

    localparam logic [BASE_W-1:0] BASE_SIZE_RST    = 5'd10;
    localparam logic [SYM_W-1:0]  SYMBOLS_LOW_RST  = 64'h3736_3534_3332_3130;
    localparam logic [SYM_W-1:0]  SYMBOLS_HIGH_RST = 64'h0000_0000_0000_3938;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_SIZE    = 2'd0,
        CFG_SYMBOLS_LOW  = 2'd1,
        CFG_SYMBOLS_HIGH = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_REJECT,
        ST_DIVIDE,
        ST_SIGN,
        ST_EMIT_RD,
        ST_EMIT_WR
    } state_t;

    function automatic logic [CHAR_W-1:0] symbol_at(
        input logic [SYM_W-1:0]   lo,
        input logic [SYM_W-1:0]   hi,
        input logic [DIGIT_W-1:0] idx
    );
        logic [SYM_W-1:0] bank;
        bank = idx[DIGIT_W-1] ? hi : lo;
        return bank[{idx[DIGIT_W-2:0], 3'b000} +: CHAR_W];
    endfunction

endpackage

[design/sird_intf.sv]
// Handshake interfaces for the radix digit converter: number input,
// character output and configuration write. Depends on sird_pkg.
`timescale 1ns / 1ps

interface sird_num_if #(
    parameter int VALUE_WIDTH = sird_pkg::VALUE_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] number;

    modport source (output valid, output number, input ready);
    modport sink (input valid, input number, output ready);
endinterface

interface sird_char_if;
    import sird_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_out;
    logic              last;
    logic              rejected;

    modport source (output valid, output char_out, output last, output rejected, input ready);
    modport sink (input valid, input char_out, input last, input rejected, output ready);
endinterface

interface sird_cfg_if;
    import sird_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [SYM_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[design/signed_integer_to_radix_digits.sv]
// Signed integer to radix digits converter: alphabet check, bit-serial
// divider, digit store and character output register.
// Depends on sird_pkg, the interfaces in sird_intf.sv and assert_macros.svh.
//
//   channel   role    word
//   numbers   sink    number (signed, VALUE_WIDTH bits)
//   chars     source  char_out, last, rejected
//   cfg       sink    index, data (base_size, symbols_low, symbols_high)
//
// The alphabet check visits each symbol in use, up to 16 of them.
// Each digit covers VALUE_WIDTH bits on the shared one-bit-per-cycle divider.
// Each character then needs a digit store read and an output write.
// Reset restores the register defaults; the digit store is not cleared.
// A stalled output holds the pending word and later words wait behind it.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module signed_integer_to_radix_digits #(
    parameter int VALUE_WIDTH = sird_pkg::VALUE_WIDTH_DEF
) (
    input logic          clk,
    input logic          rst_n,
    sird_num_if.sink     numbers,
    sird_char_if.source  chars,
    sird_cfg_if.sink     cfg
);
    import sird_pkg::*;

    localparam int W      = VALUE_WIDTH;
    localparam int ADDR_W = $clog2(W);

    logic [BASE_W-1:0] base_size_reg;
    logic [SYM_W-1:0]  symbols_low_reg;
    logic [SYM_W-1:0]  symbols_high_reg;

    state_t             state_reg, state_next;
    logic               neg_reg, neg_next;
    logic [W-1:0]       mag_reg, mag_next;
    logic [DIGIT_W-1:0] rem_reg, rem_next;
    logic               nz_reg, nz_next;
    logic [ADDR_W-1:0]  bit_cnt_reg, bit_cnt_next;
    logic [ADDR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [ADDR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [DIGIT_W-1:0] chk_idx_reg, chk_idx_next;

    logic               out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]  char_reg, char_next;
    logic               last_reg, last_next;
    logic               rej_reg, rej_next;

    logic [DIGIT_W-1:0] digit_mem [W];
    logic [DIGIT_W-1:0] rd_data_reg;
    logic               mem_we;

    logic [W-1:0]       num_u;
    logic [BASE_W-1:0]  base_top;
    logic               base_bad;
    logic               out_free;
    logic               out_load;
    logic [CHAR_W-1:0]  sym_i;
    logic               sym_bad;
    logic [BASE_W-1:0]  trial;
    logic               ge;
    logic [BASE_W-1:0]  rem_wide;

    assign numbers.ready  = (state_reg == ST_IDLE);
    assign cfg.ready      = 1'b1;
    assign chars.valid    = out_valid_reg;
    assign chars.char_out = char_reg;
    assign chars.last     = last_reg;
    assign chars.rejected = rej_reg;

    assign num_u    = numbers.number;
    assign base_top = base_size_reg - BASE_W'(1);
    assign base_bad = (base_size_reg < BASE_W'(2)) || (base_size_reg > BASE_W'(MAX_SYMBOLS));
    assign out_free = !out_valid_reg || chars.ready;

    assign trial    = {rem_reg, mag_reg[W-1]};
    assign ge       = (trial >= base_size_reg);
    assign rem_wide = ge ? (trial - base_size_reg) : trial;

    always_comb
    begin
        sym_i   = symbol_at(symbols_low_reg, symbols_high_reg, chk_idx_reg);
        sym_bad = (sym_i == CHAR_PLUS) || (sym_i == CHAR_MINUS);
        for (int j = 0; j < MAX_SYMBOLS; j++)
        begin
            if ((DIGIT_W'(j) > chk_idx_reg) && (BASE_W'(j) < base_size_reg)
                && (symbol_at(symbols_low_reg, symbols_high_reg, DIGIT_W'(j)) == sym_i))
            begin
                sym_bad = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_size_reg    <= BASE_SIZE_RST;
            symbols_low_reg  <= SYMBOLS_LOW_RST;
            symbols_high_reg <= SYMBOLS_HIGH_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg_reg_t'(cfg.index))
                CFG_BASE_SIZE:    base_size_reg    <= cfg.data[BASE_W-1:0];
                CFG_SYMBOLS_LOW:  symbols_low_reg  <= cfg.data;
                CFG_SYMBOLS_HIGH: symbols_high_reg <= cfg.data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            neg_reg       <= 1'b0;
            mag_reg       <= '0;
            rem_reg       <= '0;
            nz_reg        <= 1'b0;
            bit_cnt_reg   <= '0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            chk_idx_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            neg_reg       <= neg_next;
            mag_reg       <= mag_next;
            rem_reg       <= rem_next;
            nz_reg        <= nz_next;
            bit_cnt_reg   <= bit_cnt_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            chk_idx_reg   <= chk_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
        rej_reg  <= rej_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            digit_mem[wr_ptr_reg] <= rem_wide[DIGIT_W-1:0];
        end
        rd_data_reg <= digit_mem[rd_ptr_reg];
    end

    always_comb
    begin
        state_next   = state_reg;
        neg_next     = neg_reg;
        mag_next     = mag_reg;
        rem_next     = rem_reg;
        nz_next      = nz_reg;
        bit_cnt_next = bit_cnt_reg;
        wr_ptr_next  = wr_ptr_reg;
        rd_ptr_next  = rd_ptr_reg;
        chk_idx_next = chk_idx_reg;
        mem_we       = 1'b0;
        out_load     = 1'b0;
        char_next    = char_reg;
        last_next    = last_reg;
        rej_next     = rej_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (numbers.valid)
                begin
                    neg_next     = num_u[W-1];
                    mag_next     = num_u[W-1] ? (-num_u) : num_u;
                    chk_idx_next = '0;
                    state_next   = base_bad ? ST_REJECT : ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sym_bad)
                begin
                    state_next = ST_REJECT;
                end
                else if (chk_idx_reg == base_top[DIGIT_W-1:0])
                begin
                    rem_next     = '0;
                    nz_next      = 1'b0;
                    bit_cnt_next = '0;
                    wr_ptr_next  = '0;
                    state_next   = ST_DIVIDE;
                end
                else
                begin
                    chk_idx_next = chk_idx_reg + DIGIT_W'(1);
                end
            end
            ST_REJECT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    char_next  = CHAR_NONE;
                    last_next  = 1'b1;
                    rej_next   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DIVIDE:
            begin
                mag_next     = {mag_reg[W-2:0], ge};
                rem_next     = rem_wide[DIGIT_W-1:0];
                nz_next      = nz_reg | ge;
                bit_cnt_next = bit_cnt_reg + ADDR_W'(1);
                if (bit_cnt_reg == ADDR_W'(W - 1))
                begin
                    mem_we       = 1'b1;
                    rem_next     = '0;
                    nz_next      = 1'b0;
                    bit_cnt_next = '0;
                    if (nz_reg | ge)
                    begin
                        wr_ptr_next = wr_ptr_reg + ADDR_W'(1);
                    end
                    else
                    begin
                        rd_ptr_next = wr_ptr_reg;
                        state_next  = neg_reg ? ST_SIGN : ST_EMIT_RD;
                    end
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    char_next  = CHAR_MINUS;
                    last_next  = 1'b0;
                    rej_next   = 1'b0;
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_WR;
            end
            ST_EMIT_WR:
            begin
                if (out_free)
                begin
                    out_load  = 1'b1;
                    char_next = symbol_at(symbols_low_reg, symbols_high_reg, rd_data_reg);
                    last_next = (rd_ptr_reg == '0);
                    rej_next  = 1'b0;
                    if (rd_ptr_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        rd_ptr_next = rd_ptr_reg - ADDR_W'(1);
                        state_next  = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (chars.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // A rejected word is always the lone, final word with a null character.
    `SIRD_ASSERT_NOW(a_reject_form, chars.valid && chars.rejected,
        chars.last && (chars.char_out == CHAR_NONE), "rejected word is malformed")

    // An accepted number always moves on to the alphabet check or a rejection.
    `SIRD_ASSERT_NEXT(a_accept_next, numbers.valid && numbers.ready,
        (state_reg == ST_CHECK) || (state_reg == ST_REJECT), "bad state after accept")

    // The divider remainder stays below the radix.
    `SIRD_ASSERT_NOW(a_rem_range, state_reg == ST_DIVIDE,
        {1'b0, rem_reg} < base_size_reg, "divider remainder out of range")

    // A digit character offered to a free output register shows up next cycle.
    `SIRD_ASSERT_NEXT(a_emit_shows, (state_reg == ST_EMIT_WR) && out_free,
        chars.valid && !chars.rejected, "digit word not presented")

endmodule
